// ===== design/mmsd_pkg.sv =====
package mmsd_pkg;

    // Window length register: 7 bits, one register on the config port
    localparam int CFG_KW = 7;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Word index of the window length register (paddr[2])
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // Commands from the sequencer to the sample ring
    typedef struct packed {
        logic wr;     // store the new sample, advance write pointer
        logic start;  // rewind the read pointer to the newest sample
        logic rd;     // read one more sample while any are left
    } t_win_cmd;

    // Status from the sample ring
    typedef struct packed {
        logic more;    // samples of this pass still to be read
        logic rvalid;  // read data valid this cycle
    } t_win_stat;

endpackage

// ===== design/mmsd_window.sv =====
module mmsd_window #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mmsd_pkg::t_win_cmd                i_cmd,
    input  logic [SAMPLE_WIDTH-1:0]           i_wdata,
    input  logic [mmsd_pkg::CFG_KW-1:0]       i_k,
    output logic [SAMPLE_WIDTH-1:0]           o_rdata,
    output logic [$clog2(WINDOW_MAX+1)-1:0]   o_seen,
    output mmsd_pkg::t_win_stat               o_stat
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int KW = mmsd_pkg::CFG_KW;
    localparam logic [AW-1:0] LAST = AW'(WINDOW_MAX - 1);
    localparam logic [CW-1:0] FULL = CW'(WINDOW_MAX);

    logic [SAMPLE_WIDTH-1:0] r_mem [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] r_rdata;
    logic [AW-1:0]           r_wp;
    logic [AW-1:0]           r_raddr;
    logic [KW-1:0]           r_left;
    logic [CW-1:0]           r_seen;
    logic                    r_rvalid;
    logic                    w_fire;

    // A read goes out while the pass has samples left
    assign w_fire = i_cmd.rd && (r_left != '0) && !i_cmd.start;

    // Pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_raddr  <= '0;
            r_left   <= '0;
            r_seen   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= w_fire;
            if (i_cmd.wr) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
                if (r_seen != FULL) begin
                    r_seen <= r_seen + CW'(1);
                end
            end
            // newest sample sits one slot behind the write pointer
            if (i_cmd.start) begin
                r_raddr <= (r_wp == '0) ? LAST : r_wp - AW'(1);
                r_left  <= i_k;
            end else if (w_fire) begin
                r_raddr <= (r_raddr == '0) ? LAST : r_raddr - AW'(1);
                r_left  <= r_left - KW'(1);
            end
        end
    end

    // Sample memory; writes come only on a transfer in, reads only during
    // the passes, so the two never touch the same cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wp] <= i_wdata;
        end
        if (w_fire) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    assign o_rdata       = r_rdata;
    assign o_seen        = r_seen;
    assign o_stat.more   = (r_left != '0);
    assign o_stat.rvalid = r_rvalid;

endmodule

// ===== design/mmsd_divider.sv =====
module mmsd_divider #(
    parameter int DW = 70
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_dividend,
    input  logic [mmsd_pkg::CFG_KW-1:0]  i_divisor,
    output logic                         o_done,
    output logic [DW-1:0]                o_quotient
);

    localparam int KW   = mmsd_pkg::CFG_KW;
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_num;
    logic [KW-1:0]   r_div;
    logic [KW-1:0]   r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [KW:0]     w_rem2;
    logic [KW:0]     w_diff;
    logic            w_ge;

    // One restoring step: next dividend bit into the remainder
    always_comb begin
        w_rem2 = {r_rem, r_num[DW-1]};
        w_ge   = (w_rem2 >= {1'b0, r_div});
        w_diff = w_rem2 - {1'b0, r_div};
    end

    // Quotient bits shift in where the dividend bits leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_num  <= '0;
            r_div  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNTW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[KW-1:0] : w_rem2[KW-1:0];
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

// ===== design/mmsd_sqrt.sv =====
module mmsd_sqrt #(
    parameter int DW = 70
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_radicand,
    output logic                  o_done,
    output logic [(DW+1)/2-1:0]   o_root
);

    localparam int RW   = (DW + 1) / 2;
    localparam int PW   = 2 * RW;
    localparam int CNTW = $clog2(RW + 1);

    logic [PW-1:0]   r_rad;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW+2:0]   w_rem2;
    logic [RW+2:0]   w_trial;
    logic [RW+2:0]   w_diff;
    logic            w_ge;

    // One digit: bring in two radicand bits, try root*4+1
    always_comb begin
        w_rem2  = {r_rem, r_rad[PW-1:PW-2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
        w_diff  = w_rem2 - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rad  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= PW'(i_radicand);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(RW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[PW-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff[RW:0] : w_rem2[RW:0];
                r_root <= {r_root[RW-2:0], w_ge};
                r_cnt  <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/moving_mean_and_std_dev.sv =====
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-------------------------------------------
// sample in | i_valid / o_ready                | i_sample (signed Q16.16)
// result    | o_valid / i_ready                | o_enough_data, o_window_mean, o_window_std_dev
// config    | psel, penable, pwrite, pready=1  | paddr, pwdata, prdata (window_length at 0)
//
// One sample at a time. Not enough data: ST_CHECK goes straight to ST_DONE;
// otherwise the sum pass, the serial divider (mean), the squares pass, the serial divider
// again (S/k) and the serial square root run before ST_DONE loads the result.
// Sum pass reads one sample a cycle, squares pass only with r_phase low (two half products).
// Reset (i_rst_n low, synchronous) clears counters, sets window_length to 1, not the memory.
// A sample is taken while a result waits on i_ready; o_ready is low until o_valid rises.
module moving_mean_and_std_dev #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_enough_data,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_mean,
    output logic [SAMPLE_WIDTH-1:0]             o_window_std_dev,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mmsd_pkg::CFG_AW-1:0]         paddr,
    input  logic [mmsd_pkg::CFG_DW-1:0]         pwdata,
    output logic [mmsd_pkg::CFG_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int KW   = mmsd_pkg::CFG_KW;
    localparam int CMPW = (CW > KW) ? CW : KW;
    localparam int SUMW = SW + AW + 1;
    localparam int SQW  = 2 * SW + AW;
    localparam int HW   = (SW + 1) / 2;
    localparam int PRW  = SW + HW;
    localparam int RW   = (SQW + 1) / 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SUM, ST_MDIV, ST_SQR, ST_SDIV, ST_ROOT, ST_DONE
    } t_state;

    t_state                 r_state;
    logic [KW-1:0]          r_window_length;
    logic [KW-1:0]          r_k;
    logic                   r_enough;
    logic                   r_o_valid;
    logic                   r_o_enough;
    logic [SW-1:0]          r_o_mean;
    logic [SW-1:0]          r_o_std;
    logic                   r_phase;
    logic                   r_t2;
    logic                   r_t3;
    logic                   r_prod_vld;
    logic                   r_prod_hi;
    logic [SUMW-1:0]        r_sum;
    logic [SW-1:0]          r_mean;
    logic [SW-1:0]          r_std;
    logic [SW-1:0]          r_mag;
    logic [PRW-1:0]         r_prod;
    logic [SQW-1:0]         r_sq;

    mmsd_pkg::t_win_cmd     w_cmd;
    mmsd_pkg::t_win_stat    w_stat;
    logic [SW-1:0]          w_rdata;
    logic [CW-1:0]          w_seen;
    logic                   w_accept;
    logic                   w_cfg_wr;
    logic [KW-1:0]          w_k0;
    logic [KW-1:0]          w_k;
    logic                   w_enough;
    logic                   w_sum_neg;
    logic [SUMW-1:0]        w_sum_abs;
    logic [SQW-1:0]         w_dividend;
    logic [SQW-1:0]         w_div_q;
    logic                   w_div_done;
    logic                   w_div_start;
    logic [SW-1:0]          w_mean;
    logic [SW:0]            w_diff;
    logic [SW:0]            w_mag_full;
    logic [HW-1:0]          w_mul_b;
    logic [SQW-1:0]         w_prod_ext;
    logic                   w_sum_end;
    logic                   w_sqr_end;
    logic                   w_root_start;
    logic                   w_root_done;
    logic [RW-1:0]          w_root;
    logic                   w_out_free;

    // Config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == mmsd_pkg::REG_WINDOW_LENGTH);

    always_comb begin
        case (paddr[2])
            mmsd_pkg::REG_WINDOW_LENGTH: prdata = mmsd_pkg::CFG_DW'(r_window_length);
            default:                     prdata = '0;
        endcase
    end

    // Effective k: zero reads as one, clipped to the ring depth
    always_comb begin
        w_k0 = (r_window_length == '0) ? KW'(1) : r_window_length;
        w_k  = (CMPW'(w_k0) > CMPW'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : w_k0;
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_enough   = (CMPW'(w_seen) >= CMPW'(r_k));
    assign w_out_free = !r_o_valid || i_ready;

    // Mean: divide the magnitude, restore the sign (truncates toward zero)
    assign w_sum_neg  = r_sum[SUMW-1];
    assign w_sum_abs  = w_sum_neg ? ('0 - r_sum) : r_sum;
    assign w_mean     = w_sum_neg ? ('0 - w_div_q[SW-1:0]) : w_div_q[SW-1:0];

    // Deviation magnitude |mean - sample|, fits SW bits
    assign w_diff     = {r_mean[SW-1], r_mean} - {w_rdata[SW-1], w_rdata};
    assign w_mag_full = w_diff[SW] ? ('0 - w_diff) : w_diff;

    // Square in two halves: mag*lo, then mag*hi weighted by 2^HW
    assign w_mul_b    = r_t3 ? HW'(r_mag[SW-1:HW]) : r_mag[HW-1:0];
    assign w_prod_ext = r_prod_hi ? (SQW'(r_prod) << HW) : SQW'(r_prod);

    // Pass ends once no read or product is still in flight
    assign w_sum_end    = (r_state == ST_SUM) && !w_stat.more && !w_stat.rvalid;
    assign w_sqr_end    = (r_state == ST_SQR) && !w_stat.more && !w_stat.rvalid
                          && !r_t2 && !r_t3 && !r_prod_vld;
    assign w_div_start  = w_sum_end || w_sqr_end;
    assign w_dividend   = (r_state == ST_SUM) ? SQW'(w_sum_abs) : r_sq;
    assign w_root_start = (r_state == ST_SDIV) && w_div_done;

    // Ring commands
    assign w_cmd.wr    = w_accept;
    assign w_cmd.start = ((r_state == ST_CHECK) && w_enough)
                         || ((r_state == ST_MDIV) && w_div_done);
    assign w_cmd.rd    = (r_state == ST_SUM) || ((r_state == ST_SQR) && !r_phase);

    mmsd_window #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_wdata (i_sample),
        .i_k     (r_k),
        .o_rdata (w_rdata),
        .o_seen  (w_seen),
        .o_stat  (w_stat)
    );

    mmsd_divider #(
        .DW (SQW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_k),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    mmsd_sqrt #(
        .DW (SQW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_div_q),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // Sequencer, config register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_window_length <= KW'(1);
            r_k             <= KW'(1);
            r_enough        <= 1'b0;
            r_o_valid       <= 1'b0;
            r_o_enough      <= 1'b0;
            r_o_mean        <= '0;
            r_o_std         <= '0;
            r_phase         <= 1'b0;
            r_t2            <= 1'b0;
            r_t3            <= 1'b0;
            r_prod_vld      <= 1'b0;
            r_prod_hi       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_window_length <= pwdata[KW-1:0];
            end
            // product pipeline tokens of the squares pass
            r_t2       <= w_stat.rvalid && (r_state == ST_SQR);
            r_t3       <= r_t2;
            r_prod_vld <= r_t2 || r_t3;
            r_prod_hi  <= r_t3;
            r_phase    <= (r_state == ST_SQR) ? !r_phase : 1'b0;

            // result taken and no new one loaded this cycle
            if (r_o_valid && i_ready && !((r_state == ST_DONE) && w_out_free)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_k     <= w_k;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_enough <= w_enough;
                    r_state  <= w_enough ? ST_SUM : ST_DONE;
                end
                ST_SUM: begin
                    if (w_sum_end) begin
                        r_state <= ST_MDIV;
                    end
                end
                ST_MDIV: begin
                    if (w_div_done) begin
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (w_sqr_end) begin
                        r_state <= ST_SDIV;
                    end
                end
                ST_SDIV: begin
                    if (w_div_done) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (w_root_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_enough <= r_enough;
                        r_o_mean   <= r_mean;
                        r_o_std    <= r_std;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // running sum of the window
        if (r_state == ST_CHECK) begin
            r_sum <= '0;
        end else if ((r_state == ST_SUM) && w_stat.rvalid) begin
            r_sum <= r_sum + {{(SUMW - SW){w_rdata[SW-1]}}, w_rdata};
        end

        if ((r_state == ST_SQR) && w_stat.rvalid) begin
            r_mag <= w_mag_full[SW-1:0];
        end

        r_prod <= PRW'(r_mag) * PRW'(w_mul_b);

        // sum of squares
        if ((r_state == ST_MDIV) && w_div_done) begin
            r_sq <= '0;
        end else if (r_prod_vld) begin
            r_sq <= r_sq + w_prod_ext;
        end

        // result values; zero when the window is not yet full
        if ((r_state == ST_CHECK) && !w_enough) begin
            r_mean <= '0;
            r_std  <= '0;
        end else begin
            if ((r_state == ST_MDIV) && w_div_done) begin
                r_mean <= w_mean;
            end
            if ((r_state == ST_ROOT) && w_root_done) begin
                r_std <= w_root[SW-1:0];
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_enough_data    = r_o_enough;
    assign o_window_mean    = $signed(r_o_mean);
    assign o_window_std_dev = r_o_std;

    // Checks
    a_short_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_enough) |-> (r_o_mean == '0) && (r_o_std == '0))
        else $error("result without enough data carries nonzero values");

    a_read_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.rvalid |-> $past((r_state == ST_SUM) || (r_state == ST_SQR)))
        else $error("ring read outside of a pass");

    a_prod_in_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> (r_state == ST_SQR))
        else $error("square product left over after the squares pass");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == ST_MDIV) || (r_state == ST_SDIV)))
        else $error("divider finished while no division was pending");

endmodule
